// ===== sv/stq_pkg.sv =====
// ----------------------------------------------------------------------------
// stq_pkg: shared types and constants of the sorted countdown timer queue
// Request and result payloads, opcodes, result kinds and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package stq_pkg;

  // Default sizes, handed to the top level parameters
  localparam int DEPTH_DEF      = 16;
  localparam int DELAY_BITS_DEF = 16;
  localparam int TAG_BITS_DEF   = 8;

  // Most expirations reported for one tick
  localparam int MAX_OUT   = 16;
  localparam int MAX_OUT_W = $clog2(MAX_OUT);

  // Port field widths
  localparam int IN_DELAY_W = 16;
  localparam int IN_TAG_W   = 8;
  localparam int OUT_TAG_W  = 8;

  // Opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REJECT = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;

  typedef struct packed {
    logic                  opcode;
    logic [IN_DELAY_W-1:0] delay;
    logic [IN_TAG_W-1:0]   tag;
  } in_req_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [OUT_TAG_W-1:0] out_tag;
    logic                 last;
  } out_res_t;

  // Controller to datapath
  typedef struct packed {
    logic       latch_req;
    logic       do_insert;
    logic       do_dec;
    logic       do_pop;
    logic       load_out;
    logic [1:0] out_kind;
    logic       out_last;
  } stq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic req_op;
    logic full;
    logic empty;
    logic one_left;
    logic head_zero;
    logic next_zero;
    logic slot_free;
  } stq_stat_t;

endpackage

// ===== sv/sorted_countdown_timer_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_countdown_timer_queue: sorted countdown alarm queue
// Holds up to DEPTH alarms sorted by remaining delay; inserts and one-second
// ticks come in as requests, acceptances, rejections and expirations go out.
// ----------------------------------------------------------------------------
// Requests are handled one at a time. An insert is first captured into the
// request register; then the cell chain compares every entry against the
// new delay and shifts into place while the result enters the output
// register. A tick is captured, then all cells are decremented at once
// unless the head is already zero; expired alarms then leave one per cycle
// while the output register has room (at most 16 per tick), as expirations
// leave through the head cell of the chain one at a time.
// A result held in the output register stalls the sequence only while the
// consumer stalls.
module sorted_countdown_timer_queue
  import stq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DELAY_BITS = DELAY_BITS_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_res_t out_data
);

  stq_cmd_t  cmd;
  stq_stat_t stat;

  // Controller
  stq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Cell chain datapath
  stq_dp #(
    .DEPTH      (DEPTH),
    .DELAY_BITS (DELAY_BITS),
    .TAG_BITS   (TAG_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== sv/stq_dp.sv =====
// ----------------------------------------------------------------------------
// stq_dp: cell chain datapath of the timer queue
// Sorted chain of delay/tag cells with parallel insert, decrement and pop,
// the request holding register and the result output register.
// ----------------------------------------------------------------------------
module stq_dp
  import stq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DELAY_BITS = DELAY_BITS_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_req_t   in_data,
  input  stq_cmd_t  cmd,
  output stq_stat_t stat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_res_t  out_data
);

  localparam int OCC_W = $clog2(DEPTH + 1);

  // Held request
  logic                  req_op_r;
  logic [DELAY_BITS-1:0] req_delay_r;
  logic [TAG_BITS-1:0]   req_tag_r;

  // Cell chain
  logic [DELAY_BITS-1:0] rem_r   [DEPTH];
  logic [DELAY_BITS-1:0] rem_nxt [DEPTH];
  logic [TAG_BITS-1:0]   tag_r   [DEPTH];
  logic [TAG_BITS-1:0]   tag_nxt [DEPTH];
  logic [OCC_W-1:0]      occ_r;
  logic [OCC_W-1:0]      occ_nxt;

  // Output register
  logic     out_valid_r;
  logic     out_valid_nxt;
  out_res_t out_data_r;
  out_res_t out_data_nxt;

  logic [DEPTH-1:0] le;      // valid cell with delay <= new delay
  logic [DEPTH:0]   le_ext;  // le shifted up, position 0 always set
  logic             next_zero;
  logic             slot_free;

  // Compare of every valid cell against the new delay
  always_comb begin
    le_ext[0] = 1'b1;
    for (int i = 0; i < DEPTH; i++) begin
      le[i]       = (OCC_W'(i) < occ_r) && (rem_r[i] <= req_delay_r);
      le_ext[i+1] = le[i];
    end
  end

  // Second cell zero check, absent for a one-entry queue
  if (DEPTH > 1) begin : g_next
    assign next_zero = (rem_r[1] == '0);
  end else begin : g_single
    assign next_zero = 1'b0;
  end

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    stat.req_op    = req_op_r;
    stat.full      = (occ_r == OCC_W'(DEPTH));
    stat.empty     = (occ_r == '0);
    stat.one_left  = (occ_r == OCC_W'(1));
    stat.head_zero = (rem_r[0] == '0);
    stat.next_zero = next_zero;
    stat.slot_free = slot_free;
  end

  // Next cell contents
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      rem_nxt[i] = rem_r[i];
      tag_nxt[i] = tag_r[i];
    end
    occ_nxt = occ_r;
    if (cmd.do_insert) begin
      // new entry lands at the first cell past the thermometer, rest shift up
      for (int i = 0; i < DEPTH; i++) begin
        if (!le[i] && le_ext[i]) begin
          rem_nxt[i] = req_delay_r;
          tag_nxt[i] = req_tag_r;
        end
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (!le[i] && !le_ext[i]) begin
          rem_nxt[i] = rem_r[i-1];
          tag_nxt[i] = tag_r[i-1];
        end
      end
      occ_nxt = occ_r + OCC_W'(1);
    end else if (cmd.do_dec) begin
      for (int i = 0; i < DEPTH; i++) begin
        rem_nxt[i] = rem_r[i] - DELAY_BITS'(1);
      end
    end else if (cmd.do_pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        rem_nxt[i] = rem_r[i+1];
        tag_nxt[i] = tag_r[i+1];
      end
      occ_nxt = occ_r - OCC_W'(1);
    end
  end

  // Next output register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (cmd.load_out) begin
      out_valid_nxt        = 1'b1;
      out_data_nxt.kind    = cmd.out_kind;
      out_data_nxt.last    = cmd.out_last;
      if (cmd.out_kind == KIND_EXPIRE) begin
        out_data_nxt.out_tag = OUT_TAG_W'(tag_r[0]);
      end else begin
        out_data_nxt.out_tag = OUT_TAG_W'(req_tag_r);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_req) begin
      req_op_r    <= in_data.opcode;
      req_delay_r <= DELAY_BITS'(in_data.delay);
      req_tag_r   <= TAG_BITS'(in_data.tag);
    end
    for (int i = 0; i < DEPTH; i++) begin
      rem_r[i] <= rem_nxt[i];
      tag_r[i] <= tag_nxt[i];
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_pop |-> (stat.head_zero && !stat.empty))
    else $error("pop without an expired head");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_insert |-> !stat.full)
    else $error("insert into full queue");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> slot_free)
    else $error("pending result overwritten");

endmodule

// ===== sv/stq_ctrl.sv =====
// ----------------------------------------------------------------------------
// stq_ctrl: sequencing controller of the timer queue
// Accepts one request at a time, issues the insert or the decrement, then
// pops expired heads into the output register one per cycle while it has room.
// ----------------------------------------------------------------------------
module stq_ctrl
  import stq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  stq_stat_t stat,
  output logic      in_stall,
  output stq_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;

  logic [1:0]           state_r;
  logic [1:0]           state_nxt;
  logic [MAX_OUT_W-1:0] cnt_r;
  logic [MAX_OUT_W-1:0] cnt_nxt;
  logic                 pop_last;

  assign in_stall = (state_r != ST_IDLE);

  // final expiration of this tick
  assign pop_last = stat.one_left || !stat.next_zero ||
                    (cnt_r == MAX_OUT_W'(MAX_OUT - 1));

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_req = 1'b1;
          state_nxt     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.req_op == OP_INSERT) begin
          if (stat.slot_free) begin
            cmd.load_out  = 1'b1;
            cmd.out_last  = 1'b1;
            cmd.out_kind  = stat.full ? KIND_REJECT : KIND_ACCEPT;
            cmd.do_insert = !stat.full;
            state_nxt     = ST_IDLE;
          end
        end else begin
          cmd.do_dec = !stat.empty && !stat.head_zero;
          cnt_nxt    = '0;
          state_nxt  = ST_POP;
        end
      end
      ST_POP: begin
        if (stat.empty || !stat.head_zero) begin
          state_nxt = ST_IDLE;
        end else if (stat.slot_free) begin
          cmd.do_pop   = 1'b1;
          cmd.load_out = 1'b1;
          cmd.out_kind = KIND_EXPIRE;
          cmd.out_last = pop_last;
          cnt_nxt      = cnt_r + MAX_OUT_W'(1);
          if (pop_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Checks
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.do_insert, cmd.do_dec, cmd.do_pop}))
    else $error("conflicting cell chain commands");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && cmd.out_last) |=> (state_r == ST_IDLE))
    else $error("final result did not end the request");

  a_pop_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_pop |-> (state_r == ST_POP))
    else $error("pop outside expiration phase");

endmodule

// ===== test/stq_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stq_event_checker: result checker for the sorted countdown timer queue
// Watches the request and result channels. It keeps a shadow of the alarm
// list, works out the results of each accepted request, and compares every
// accepted result against the oldest one still awaited.
// ----------------------------------------------------------------------------
module stq_event_checker
  import stq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  in_req_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  out_res_t out_data,
  output int       fail_count,
  output int       events_pending,
  output int       expiries_seen,
  output int       rejects_seen
);

  // Shadow alarm list, sorted by ascending delay
  logic [DELAY_BITS_DEF-1:0] slot_delay [DEPTH_DEF];
  logic [TAG_BITS_DEF-1:0]   slot_tag   [DEPTH_DEF];
  int                        slots_used = 0;

  // Results still owed by the block, oldest first
  out_res_t alarm_events_q [$];

  int mismatches  = 0;
  int expiries    = 0;
  int rejects     = 0;
  int pending_cnt = 0;

  assign fail_count     = mismatches;
  assign events_pending = pending_cnt;
  assign expiries_seen  = expiries;
  assign rejects_seen   = rejects;

  // Apply one request to the shadow list and queue the results it causes
  task automatic predict_alarm_events(input in_req_t r);
    logic [DELAY_BITS_DEF-1:0] d;
    logic [TAG_BITS_DEF-1:0]   t;
    int                        pos;
    int                        n;
    out_res_t                  ev;
    d = r.delay[DELAY_BITS_DEF-1:0];
    t = r.tag[TAG_BITS_DEF-1:0];
    if (r.opcode == OP_INSERT) begin
      ev.out_tag = t;
      ev.last    = 1'b1;
      if (slots_used >= DEPTH_DEF) begin
        ev.kind = KIND_REJECT;
      end else begin
        // new alarm goes after every entry with a delay not above its own
        pos = 0;
        while (pos < slots_used && slot_delay[pos] <= d) pos++;
        for (int i = slots_used; i > pos; i--) begin
          slot_delay[i] = slot_delay[i-1];
          slot_tag[i]   = slot_tag[i-1];
        end
        slot_delay[pos] = d;
        slot_tag[pos]   = t;
        slots_used++;
        ev.kind = KIND_ACCEPT;
      end
      alarm_events_q.push_back(ev);
    end else if (slots_used > 0) begin
      // a zero head means leftovers: no countdown this time
      if (slot_delay[0] != '0) begin
        for (int i = 0; i < slots_used; i++) slot_delay[i] = slot_delay[i] - 1'b1;
      end
      n = 0;
      while (n < slots_used && n < MAX_OUT && slot_delay[n] == '0) n++;
      for (int i = 0; i < n; i++) begin
        ev.kind    = KIND_EXPIRE;
        ev.out_tag = slot_tag[i];
        ev.last    = (i == n - 1);
        alarm_events_q.push_back(ev);
      end
      for (int i = n; i < slots_used; i++) begin
        slot_delay[i-n] = slot_delay[i];
        slot_tag[i-n]   = slot_tag[i];
      end
      slots_used -= n;
    end
  endtask

  // Requests first, then results; a result never follows its request in
  // the same cycle, so the order only matters for robustness
  always @(posedge clk) begin
    out_res_t exp_ev;
    if (rst_n) begin
      if (in_valid && !in_stall) predict_alarm_events(in_data);
      if (out_valid && !out_stall) begin
        if (alarm_events_q.size() == 0) begin
          $error("unexpected result: kind=%0d out_tag=%0h last=%0d",
                 out_data.kind, out_data.out_tag, out_data.last);
          mismatches++;
        end else begin
          exp_ev = alarm_events_q.pop_front();
          if (out_data.kind !== exp_ev.kind) begin
            $error("kind: expected %0d, got %0d", exp_ev.kind, out_data.kind);
            mismatches++;
          end
          if (out_data.out_tag !== exp_ev.out_tag) begin
            $error("out_tag: expected %0h, got %0h", exp_ev.out_tag, out_data.out_tag);
            mismatches++;
          end
          if (out_data.last !== exp_ev.last) begin
            $error("last: expected %0d, got %0d", exp_ev.last, out_data.last);
            mismatches++;
          end
          if (exp_ev.kind == KIND_EXPIRE) expiries++;
          if (exp_ev.kind == KIND_REJECT) rejects++;
        end
      end
      pending_cnt = alarm_events_q.size();
    end
  end

endmodule

// ===== test/sorted_countdown_timer_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_countdown_timer_queue_tb: testbench of the sorted countdown timer queue
// Drives a directed set of inserts and ticks (full queue, equal delays, a
// tick that empties the whole queue, zero and maximum delays), then random
// traffic under three idle and stall mixes; the checker judges every result.
// ----------------------------------------------------------------------------
module sorted_countdown_timer_queue_tb
  import stq_pkg::*;
;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  in_req_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     in_stall;
  logic     out_valid;
  out_res_t out_data;

  int fail_count;
  int events_pending;
  int expiries_seen;
  int rejects_seen;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int inserts_sent   = 0;
  int ticks_sent     = 0;

  sorted_countdown_timer_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  stq_event_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .events_pending (events_pending),
    .expiries_seen  (expiries_seen),
    .rejects_seen   (rejects_seen)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hang guard
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
  end

  // Offer one request after a random gap and hold it until taken
  task automatic push_request(input in_req_t r);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < src_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic issue_insert(input logic [IN_DELAY_W-1:0] d, input logic [IN_TAG_W-1:0] t);
    in_req_t r;
    r.opcode = OP_INSERT;
    r.delay  = d;
    r.tag    = t;
    push_request(r);
    inserts_sent++;
  endtask

  // Tick payload fields are don't-care; fill them with noise
  task automatic issue_tick();
    in_req_t r;
    r.opcode = OP_TICK;
    r.delay  = IN_DELAY_W'($urandom);
    r.tag    = IN_TAG_W'($urandom);
    push_request(r);
    ticks_sent++;
  endtask

  // Mostly short delays so alarms actually fire; a few huge ones linger
  task automatic random_request();
    int roll;
    logic [IN_DELAY_W-1:0] d;
    roll = $urandom_range(0, 99);
    if (roll < 52) begin
      roll = $urandom_range(0, 99);
      if (roll < 75)      d = IN_DELAY_W'($urandom_range(0, 5));
      else if (roll < 95) d = IN_DELAY_W'($urandom_range(6, 20));
      else                d = IN_DELAY_W'($urandom);
      issue_insert(d, IN_TAG_W'($urandom));
    end else begin
      issue_tick();
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    src_idle_pct   = 38;
    sink_stall_pct = 51;

    // empty queue: tick gives nothing
    issue_tick();
    // fill with equal delays; ties must keep arrival order
    for (int k = 0; k < DEPTH_DEF; k++) issue_insert(16'd1, IN_TAG_W'(k * 17));
    // full queue rejects
    issue_insert(16'hFFFF, 8'hFF);
    // every entry expires on one tick
    issue_tick();
    // zero delay fires on the next tick without a countdown
    issue_insert(16'd0, 8'h5A);
    issue_insert(16'hFFFF, 8'h00);
    issue_tick();
    // countdown with nothing reaching zero
    issue_tick();

    // random traffic under three idle mixes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct   = 38;
          sink_stall_pct = 51;
        end
        1: begin
          src_idle_pct   = 51;
          sink_stall_pct = 38;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
      endcase
      repeat (62) random_request();
    end

    // drain, then watch a while for strays
    in_valid <= 1'b0;
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Sent %0d inserts and %0d ticks under three idle mixes;",
             inserts_sent, ticks_sent);
    $display("checked %0d expirations and %0d full-queue rejections.",
             expiries_seen, rejects_seen);
    if (fail_count == 0 && events_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
